// ----- rtl/core/rcp_pkg.sv -----
// Package for the remote-control command line parser.
// Holds character codes, result kind codes and the beat and result types shared by the modules.
// Has no dependencies.
package rcp_pkg;

  localparam logic [7:0] CharNul  = 8'h00;
  localparam logic [7:0] CharLf   = 8'h0A;
  localparam logic [7:0] CharS    = 8'h53;
  localparam logic [7:0] CharArm  = 8'h44;
  localparam logic [7:0] CharDis  = 8'h64;
  localparam logic [7:0] CharPOn  = 8'h50;
  localparam logic [7:0] CharPOff = 8'h70;
  localparam logic [7:0] CharEcho = 8'h5A;
  localparam logic [7:0] CharT    = 8'h54;
  localparam logic [7:0] CharR    = 8'h52;
  localparam logic [7:0] CharP    = 8'h50;
  localparam logic [7:0] CharX    = 8'h58;
  localparam logic [7:0] CharY    = 8'h59;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  localparam logic [2:0] MaxDigits = 3'd4;

  localparam logic [2:0] KindArm       = 3'd0;
  localparam logic [2:0] KindDisarm    = 3'd1;
  localparam logic [2:0] KindPoliceOn  = 3'd2;
  localparam logic [2:0] KindPoliceOff = 3'd3;
  localparam logic [2:0] KindEcho      = 3'd4;
  localparam logic [2:0] KindYawThr    = 3'd5;
  localparam logic [2:0] KindRollPitch = 3'd6;

  localparam logic [13:0] FirstOffset  = 14'd1000;
  localparam logic [13:0] SecondOffset = 14'd2000;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_armed;
  } beat_t;

  typedef struct packed {
    logic              has_result;
    logic [2:0]        kind;
    logic [13:0]       first_value;
    logic signed [13:0] second_value;
  } result_t;

endpackage

// ----- rtl/core/rcp_in_reg.sv -----
// Input register of the command line parser.
// Captures one beat and holds it until the parser takes it; uses rcp_pkg.
module rcp_in_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  rcp_pkg::beat_t in_beat,
  input  logic           take,
  output logic           held_valid,
  output rcp_pkg::beat_t held_beat
);

  assign in_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      held_beat <= in_beat;
    end
  end

endmodule

// ----- rtl/core/rcp_parser.sv -----
// Parser state and per-byte decoding for the command line parser.
// Updates the line state on each taken beat and forms at most one result; uses rcp_pkg.
module rcp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  rcp_pkg::beat_t   beat,
  output rcp_pkg::result_t result
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEAD,
    PH_XDIG,
    PH_YDIG
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  first_letter, first_letter_next;
  logic [7:0]  second_letter, second_letter_next;
  logic [1:0]  position, position_next;
  logic [13:0] x_accum, x_accum_next;
  logic [13:0] y_accum, y_accum_next;
  logic [2:0]  digit_count, digit_count_next;
  logic        form_valid, form_valid_next;

  logic [7:0]  b;
  logic        is_digit;
  logic        digit_ok;
  logic [13:0] digit_val;
  logic        coord_ok;

  assign b         = beat.rx_byte;
  assign is_digit  = (b >= rcp_pkg::CharZero) && (b <= rcp_pkg::CharNine);
  assign digit_ok  = is_digit && (digit_count < rcp_pkg::MaxDigits);
  assign digit_val = {6'd0, 8'(b - rcp_pkg::CharZero)};
  assign coord_ok  = form_valid && (phase == PH_YDIG) && (digit_count != 3'd0);

  always_comb begin
    phase_next         = phase;
    first_letter_next  = first_letter;
    second_letter_next = second_letter;
    position_next      = position;
    x_accum_next       = x_accum;
    y_accum_next       = y_accum;
    digit_count_next   = digit_count;
    form_valid_next    = form_valid;
    result             = '0;

    if (b == rcp_pkg::CharS || b == rcp_pkg::CharLf) begin
      first_letter_next  = 8'd0;
      second_letter_next = 8'd0;
      position_next      = 2'd0;
      x_accum_next       = 14'd0;
      y_accum_next       = 14'd0;
      digit_count_next   = 3'd0;
      form_valid_next    = 1'b1;
    end

    if (b == rcp_pkg::CharNul) begin
      result.has_result = 1'b0;
    end else if (b == rcp_pkg::CharS) begin
      phase_next = PH_HEAD;
    end else if (b == rcp_pkg::CharLf) begin
      if (phase == PH_IDLE) begin
        first_letter_next  = first_letter;
        second_letter_next = second_letter;
        position_next      = position;
        x_accum_next       = x_accum;
        y_accum_next       = y_accum;
        digit_count_next   = digit_count;
        form_valid_next    = form_valid;
      end else begin
        phase_next = PH_IDLE;
        if (position != 2'd0) begin
          unique case (first_letter)
            rcp_pkg::CharArm: begin
              result.has_result = !beat.is_armed;
              result.kind       = rcp_pkg::KindArm;
            end
            rcp_pkg::CharDis: begin
              result.has_result = beat.is_armed;
              result.kind       = rcp_pkg::KindDisarm;
            end
            rcp_pkg::CharPOn: begin
              result.has_result = 1'b1;
              result.kind       = rcp_pkg::KindPoliceOn;
            end
            rcp_pkg::CharPOff: begin
              result.has_result = 1'b1;
              result.kind       = rcp_pkg::KindPoliceOff;
            end
            rcp_pkg::CharEcho: begin
              result.has_result = 1'b1;
              result.kind       = rcp_pkg::KindEcho;
            end
            default: begin
              result.first_value  = x_accum + rcp_pkg::FirstOffset;
              result.second_value = $signed(rcp_pkg::SecondOffset - y_accum);
              if (coord_ok && first_letter == rcp_pkg::CharT
                  && second_letter == rcp_pkg::CharY) begin
                result.has_result = 1'b1;
                result.kind       = rcp_pkg::KindYawThr;
              end else if (coord_ok && first_letter == rcp_pkg::CharR
                  && second_letter == rcp_pkg::CharP) begin
                result.has_result = 1'b1;
                result.kind       = rcp_pkg::KindRollPitch;
              end
            end
          endcase
        end
      end
    end else if (phase != PH_IDLE) begin
      if (position != 2'd2) begin
        position_next = position + 2'd1;
      end
      if (position == 2'd0) begin
        first_letter_next = b;
      end else if (position == 2'd1) begin
        second_letter_next = b;
      end else if (form_valid) begin
        unique case (phase)
          PH_HEAD: begin
            if (b == rcp_pkg::CharX) begin
              phase_next       = PH_XDIG;
              digit_count_next = 3'd0;
            end else begin
              form_valid_next = 1'b0;
            end
          end
          PH_XDIG: begin
            if (digit_ok) begin
              x_accum_next     = 14'(x_accum * 14'd10 + digit_val);
              digit_count_next = digit_count + 3'd1;
            end else if (b == rcp_pkg::CharY) begin
              phase_next       = PH_YDIG;
              digit_count_next = 3'd0;
            end else begin
              form_valid_next = 1'b0;
            end
          end
          default: begin
            if (digit_ok) begin
              y_accum_next     = 14'(y_accum * 14'd10 + digit_val);
              digit_count_next = digit_count + 3'd1;
            end else begin
              form_valid_next = 1'b0;
            end
          end
        endcase
      end
    end

    if (!result.has_result) begin
      result.kind         = 3'd0;
      result.first_value  = 14'd0;
      result.second_value = 14'sd0;
    end else if (result.kind != rcp_pkg::KindYawThr
        && result.kind != rcp_pkg::KindRollPitch) begin
      result.first_value  = 14'd0;
      result.second_value = 14'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      first_letter  <= 8'd0;
      second_letter <= 8'd0;
      position      <= 2'd0;
      x_accum       <= 14'd0;
      y_accum       <= 14'd0;
      digit_count   <= 3'd0;
      form_valid    <= 1'b1;
    end else if (take) begin
      phase         <= phase_next;
      first_letter  <= first_letter_next;
      second_letter <= second_letter_next;
      position      <= position_next;
      x_accum       <= x_accum_next;
      y_accum       <= y_accum_next;
      digit_count   <= digit_count_next;
      form_valid    <= form_valid_next;
    end
  end

endmodule

// ----- rtl/core/rcp_out_reg.sv -----
// Result register of the command line parser.
// Holds one result beat until the receiver takes it; uses rcp_pkg.
module rcp_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  rcp_pkg::result_t   result,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         kind,
  output logic [13:0]        first_value,
  output logic signed [13:0] second_value
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= take && result.has_result;
    end
    if (out_free && take && result.has_result) begin
      kind         <= result.kind;
      first_value  <= result.first_value;
      second_value <= result.second_value;
    end
  end

endmodule

// ----- rtl/core/rc_command_line_parser.sv -----
// Remote-control command line parser: one received byte per beat, at most one command out.
// A line's result passes from its newline beat through the input and result registers.
// One input beat is taken per cycle while the result side is not stalled.
// The input register and the result register decouple the two channels.
// Synchronous active-high reset returns the parser to idle with an empty line.
module rc_command_line_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               is_armed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         kind,
  output logic [13:0]        first_value,
  output logic signed [13:0] second_value
);

  rcp_pkg::beat_t   in_beat;
  rcp_pkg::beat_t   held_beat;
  rcp_pkg::result_t result;
  logic             held_valid;
  logic             out_free;
  logic             take;

  assign in_beat.rx_byte  = rx_byte;
  assign in_beat.is_armed = is_armed;
  assign take             = held_valid && out_free;

  rcp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .take       (take),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  rcp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .beat   (held_beat),
    .result (result)
  );

  rcp_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .result       (result),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .first_value  (first_value),
    .second_value (second_value)
  );

endmodule
